FILE: src/ccfh_pkg.sv
// Chain command frame handler: shared constants, response kinds and canned replies.
// No dependencies; imported by the top level.
package ccfh_pkg;

  localparam logic [7:0] CH_NL = 8'h0A;
  localparam logic [7:0] CH_C = 8'h43;
  localparam logic [7:0] CH_D = 8'h44;
  localparam logic [7:0] TEMP_OFF = 8'h80;
  localparam logic [7:0] VERSION_RST = 8'h01;

  localparam logic [7:0] CMD_IDENT = 8'd0;
  localparam logic [7:0] CMD_SET_ADDR = 8'd1;
  localparam logic [7:0] CMD_SET_ECHO = 8'd2;
  localparam logic [7:0] CMD_INC_ADDR = 8'd3;
  localparam logic [7:0] CMD_REPORT = 8'd4;
  localparam logic [7:0] CMD_ECHO = 8'd5;
  localparam logic [7:0] CMD_RESET = 8'd6;
  localparam logic [7:0] CMD_RESET_ECHO = 8'd7;
  localparam logic [7:0] CMD_LIMIT = 8'd8;
  localparam logic [7:0] CMD_LIMIT_ECHO = 8'd9;
  localparam logic [7:0] CMD_CLEAR = 8'd10;
  localparam logic [7:0] CMD_CLEAR_ECHO = 8'd11;

  typedef enum logic {
    RSP_IDENT,
    RSP_ADDR
  } rsp_e;

  function automatic logic [7:0] canned_byte(rsp_e kind, logic [2:0] idx,
                                             logic [7:0] board, logic [7:0] version);
    logic [7:0] b;
    b = 8'h00;
    if (kind == RSP_IDENT) begin
      case (idx)
        3'd0: b = CH_C;
        3'd1: b = 8'hFF;
        3'd2: b = board;
        3'd3: b = version;
        3'd4: b = 8'h00;
        3'd5: b = ~board;
        3'd6: b = ~version;
        default: b = CH_NL;
      endcase
    end else begin
      case (idx)
        3'd0: b = CH_C;
        3'd1: b = 8'h05;
        3'd2: b = board;
        3'd3: b = 8'hFA;
        3'd4: b = ~board;
        default: b = CH_NL;
      endcase
    end
    return b;
  endfunction

  function automatic logic canned_last(rsp_e kind, logic [2:0] idx);
    return (kind == RSP_IDENT) ? (idx == 3'd7) : (idx == 3'd5);
  endfunction

endpackage

FILE: src/ccfh_line_store.sv
// Line store for the chain command frame handler: one write port, one
// registered read port. No dependencies.
module ccfh_line_store #(
  parameter int unsigned Depth = 64,
  localparam int unsigned AW = $clog2(Depth)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem_q [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/chain_command_frame_handler.sv
// Chain command frame handler: top level with the frame sequencer and state registers.
// Depends on ccfh_pkg and ccfh_line_store.
//
// Usage:
//  s_axis carries one received serial byte per item (tdata[7:0]).
//  m_axis returns the results of each byte: tuser = tx_valid (byte to send),
//  tlast = last result of that byte, tdata holds the byte and the live status.
//  cfg_we_i/cfg_wdata_i write the version byte reported by the identify command.
//  Flow: a byte that does not close a frame is accepted, then its status item
//  leaves the output register. A newline runs the sequencer: it reads the lead
//  byte, checks the payload pairs through the single line store read port,
//  reads command and argument, then forwards the frame bytes or sends the
//  canned reply bytes, or only a status item.
//  s_axis_tready_o is low while the sequencer runs or a result is pending.
//  Receiver stall: the output register holds its item and the sequencer waits.
//  Reset: board address 0, limit and release -128, no reset request, version 1,
//  empty line; the store contents are not cleared.
module chain_command_frame_handler
  import ccfh_pkg::*;
#(
  parameter int unsigned LINE_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [7:0] tx_byte, [15:8] board_address,
                                        // [23:16] overheat_limit, [31:24] release_temp,
                                        // [32] reset_request, [39:33] zero
  output logic        m_axis_tuser_o,   // [0] tx_valid
  output logic        m_axis_tlast_o    // last_of_run
);

  localparam int unsigned AW = $clog2(LINE_DEPTH);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LEAD = 4'd1;
  localparam logic [3:0] S_LEADW = 4'd2;
  localparam logic [3:0] S_SA = 4'd3;
  localparam logic [3:0] S_SB = 4'd4;
  localparam logic [3:0] S_SC = 4'd5;
  localparam logic [3:0] S_CMD = 4'd6;
  localparam logic [3:0] S_CMD1 = 4'd7;
  localparam logic [3:0] S_EXEC = 4'd8;
  localparam logic [3:0] S_INC4 = 4'd9;
  localparam logic [3:0] S_FRD = 4'd10;
  localparam logic [3:0] S_FOUT = 4'd11;
  localparam logic [3:0] S_CAN = 4'd12;
  localparam logic [3:0] S_STAT = 4'd13;

  logic [3:0]    state_q, state_d;
  logic [AW-1:0] fill_q, fill_d;
  logic [AW-1:0] len_q, len_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [AW-1:0] half_q, half_d;
  logic [7:0]    cmd_q, cmd_d;
  logic [7:0]    arg_q, arg_d;
  logic [7:0]    a_q, a_d;
  rsp_e          kind_q, kind_d;
  logic [7:0]    board_q, board_d;
  logic [7:0]    limit_q, limit_d;
  logic [7:0]    clear_q, clear_d;
  logic          rstp_q, rstp_d;
  logic [7:0]    version_q;

  logic          out_valid_q;
  logic [7:0]    out_byte_q;
  logic          out_txv_q;
  logic          out_last_q;

  logic          push, push_txv, push_last;
  logic [7:0]    push_byte;
  logic          can_push;
  logic          accept;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata, mem_rdata;

  ccfh_line_store #(
    .Depth(LINE_DEPTH)
  ) u_line_store (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign can_push = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == S_IDLE) && !out_valid_q;
  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    state_d = state_q;
    fill_d = fill_q;
    len_d = len_q;
    idx_d = idx_q;
    half_d = half_q;
    cmd_d = cmd_q;
    arg_d = arg_q;
    a_d = a_q;
    kind_d = kind_q;
    board_d = board_q;
    limit_d = limit_q;
    clear_d = clear_q;
    rstp_d = rstp_q;
    push = 1'b0;
    push_txv = 1'b0;
    push_last = 1'b1;
    push_byte = 8'h00;
    mem_we = 1'b0;
    mem_waddr = fill_q;
    mem_wdata = s_axis_tdata_i;
    mem_re = 1'b0;
    mem_raddr = idx_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (rstp_q) begin
            push = 1'b1;
          end else begin
            mem_we = 1'b1;
            if (fill_q == AW'(LINE_DEPTH - 1)) begin
              fill_d = '0;
              push = 1'b1;
            end else if (s_axis_tdata_i != CH_NL) begin
              fill_d = fill_q + AW'(1);
              push = 1'b1;
            end else begin
              len_d = fill_q + AW'(1);
              fill_d = '0;
              state_d = S_LEAD;
            end
          end
        end
      end
      S_LEAD: begin
        mem_re = 1'b1;
        mem_raddr = '0;
        state_d = S_LEADW;
      end
      S_LEADW: begin
        idx_d = '0;
        if (mem_rdata == CH_D) begin
          state_d = S_FRD;
        end else if (mem_rdata == CH_C && len_q >= AW'(4) && !len_q[0]) begin
          half_d = (len_q - AW'(2)) >> 1;
          state_d = S_SA;
        end else begin
          state_d = S_STAT;
        end
      end
      S_SA: begin
        mem_re = 1'b1;
        mem_raddr = AW'(1) + idx_q;
        state_d = S_SB;
      end
      S_SB: begin
        mem_re = 1'b1;
        mem_raddr = AW'(1) + half_q + idx_q;
        a_d = mem_rdata;
        state_d = S_SC;
      end
      S_SC: begin
        if (a_q != ~mem_rdata) begin
          state_d = S_STAT;
        end else if (idx_q + AW'(1) == half_q) begin
          state_d = S_CMD;
        end else begin
          idx_d = idx_q + AW'(1);
          state_d = S_SA;
        end
      end
      S_CMD: begin
        mem_re = 1'b1;
        mem_raddr = AW'(1);
        state_d = S_CMD1;
      end
      S_CMD1: begin
        cmd_d = mem_rdata;
        mem_re = 1'b1;
        mem_raddr = AW'(2);
        state_d = S_EXEC;
      end
      S_EXEC: begin
        idx_d = '0;
        state_d = S_STAT;
        case (cmd_q)
          CMD_IDENT: begin
            kind_d = RSP_IDENT;
            state_d = S_CAN;
          end
          CMD_SET_ADDR: board_d = mem_rdata;
          CMD_SET_ECHO: begin
            board_d = mem_rdata;
            state_d = S_FRD;
          end
          CMD_INC_ADDR: begin
            board_d = mem_rdata;
            arg_d = mem_rdata + 8'd1;
            mem_we = 1'b1;
            mem_waddr = AW'(2);
            mem_wdata = mem_rdata + 8'd1;
            state_d = (len_q > AW'(4)) ? S_INC4 : S_FRD;
          end
          CMD_REPORT: begin
            kind_d = RSP_ADDR;
            state_d = S_CAN;
          end
          CMD_ECHO: state_d = S_FRD;
          CMD_RESET: rstp_d = 1'b1;
          CMD_RESET_ECHO: begin
            rstp_d = 1'b1;
            state_d = S_FRD;
          end
          CMD_LIMIT: limit_d = mem_rdata;
          CMD_LIMIT_ECHO: begin
            limit_d = mem_rdata;
            state_d = S_FRD;
          end
          CMD_CLEAR: clear_d = mem_rdata;
          CMD_CLEAR_ECHO: begin
            clear_d = mem_rdata;
            state_d = S_FRD;
          end
          default: state_d = S_STAT;
        endcase
      end
      S_INC4: begin
        mem_we = 1'b1;
        mem_waddr = AW'(4);
        mem_wdata = ~arg_q;
        state_d = S_FRD;
      end
      S_FRD: begin
        mem_re = 1'b1;
        mem_raddr = idx_q;
        state_d = S_FOUT;
      end
      S_FOUT: begin
        if (can_push) begin
          push = 1'b1;
          push_txv = 1'b1;
          push_byte = mem_rdata;
          push_last = (idx_q == len_q - AW'(1));
          if (push_last) begin
            state_d = S_IDLE;
          end else begin
            idx_d = idx_q + AW'(1);
            state_d = S_FRD;
          end
        end
      end
      S_CAN: begin
        if (can_push) begin
          push = 1'b1;
          push_txv = 1'b1;
          push_byte = canned_byte(kind_q, idx_q[2:0], board_q, version_q);
          push_last = canned_last(kind_q, idx_q[2:0]);
          if (push_last) begin
            state_d = S_IDLE;
          end else begin
            idx_d = idx_q + AW'(1);
          end
        end
      end
      S_STAT: begin
        if (can_push) begin
          push = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q <= '0;
      board_q <= 8'h00;
      limit_q <= TEMP_OFF;
      clear_q <= TEMP_OFF;
      rstp_q <= 1'b0;
      version_q <= VERSION_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q <= fill_d;
      board_q <= board_d;
      limit_q <= limit_d;
      clear_q <= clear_d;
      rstp_q <= rstp_d;
      if (cfg_we_i) begin
        version_q <= cfg_wdata_i;
      end
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    len_q <= len_d;
    idx_q <= idx_d;
    half_q <= half_d;
    cmd_q <= cmd_d;
    arg_q <= arg_d;
    a_q <= a_d;
    kind_q <= kind_d;
    if (push) begin
      out_byte_q <= push_byte;
      out_txv_q <= push_txv;
      out_last_q <= push_last;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o = out_txv_q;
  assign m_axis_tlast_o = out_last_q;
  assign m_axis_tdata_o = {7'd0, rstp_q, clear_q, limit_q, board_q, out_byte_q};

endmodule
